FILE: rtl/swq_pkg.sv
`default_nettype none

package swq_pkg;

   typedef enum logic [1:0] {
      FUNC_INSERT = 2'd0,
      FUNC_REMOVE = 2'd1,
      FUNC_POP    = 2'd2,
      FUNC_POP_IF = 2'd3
   } func_type;

   typedef enum logic [2:0] {
      STAT_OK        = 3'd0,
      STAT_EMPTY     = 3'd1,
      STAT_NOT_FOUND = 3'd2,
      STAT_FULL      = 3'd3,
      STAT_BELOW     = 3'd4
   } status_type;

   // command broadcast to every cell of the chain
   typedef enum logic [2:0] {
      CMD_HOLD,
      CMD_INSERT,
      CMD_POP,
      CMD_WAVE,
      CMD_REMOVE
   } cmd_type;

   typedef enum logic [1:0] {
      FSM_IDLE,
      FSM_WAVE,
      FSM_REMOVE
   } fsm_type;

   // flags one cell shows to its neighbours
   typedef struct packed {
      logic valid;
      logic ins_cond;
      logic seen;
   } cell_flags_type;

   localparam int PRIO_BITS = 32;

endpackage

`default_nettype wire

FILE: rtl/swq_cell.sv
`default_nettype none

module swq_cell #(
   parameter int HANDLE_BITS = 8
) (
   input  wire                              clock,
   input  wire                              reset,
   input  swq_pkg::cmd_type                 cmd,
   input  wire  [HANDLE_BITS-1:0]           ins_handle,
   input  wire  [swq_pkg::PRIO_BITS-1:0]    ins_prio,
   input  wire  [HANDLE_BITS-1:0]           rem_handle,
   input  swq_pkg::cell_flags_type          left_flags,
   input  wire  [HANDLE_BITS-1:0]           left_handle,
   input  wire  [swq_pkg::PRIO_BITS-1:0]    left_prio,
   input  swq_pkg::cell_flags_type          right_flags,
   input  wire  [HANDLE_BITS-1:0]           right_handle,
   input  wire  [swq_pkg::PRIO_BITS-1:0]    right_prio,
   output swq_pkg::cell_flags_type          flags,
   output logic [HANDLE_BITS-1:0]           handle,
   output logic [swq_pkg::PRIO_BITS-1:0]    prio
);

   logic                          valid_ff, valid_in;
   logic [HANDLE_BITS-1:0]        handle_ff, handle_in;
   logic [swq_pkg::PRIO_BITS-1:0] prio_ff, prio_in;
   logic                          seen_ff, seen_in;
   logic                          ins_cond;
   logic                          match;

   // the new item belongs here or nearer the head of the chain
   assign ins_cond = !valid_ff || (prio_ff <= ins_prio);
   assign match    = valid_ff && (handle_ff == rem_handle);

   assign flags.valid    = valid_ff;
   assign flags.ins_cond = ins_cond;
   assign flags.seen     = seen_ff || match;
   assign handle         = handle_ff;
   assign prio           = prio_ff;

   always_comb begin
      valid_in  = valid_ff;
      handle_in = handle_ff;
      prio_in   = prio_ff;
      seen_in   = seen_ff;
      unique case (cmd)
         swq_pkg::CMD_INSERT: begin
            if (ins_cond) begin
               if (left_flags.ins_cond) begin
                  // shift down from the left neighbour
                  valid_in  = left_flags.valid;
                  handle_in = left_handle;
                  prio_in   = left_prio;
               end else begin
                  valid_in  = 1'b1;
                  handle_in = ins_handle;
                  prio_in   = ins_prio;
               end
            end
         end
         swq_pkg::CMD_POP: begin
            valid_in  = right_flags.valid;
            handle_in = right_handle;
            prio_in   = right_prio;
         end
         swq_pkg::CMD_WAVE: begin
            seen_in = left_flags.seen;
         end
         swq_pkg::CMD_REMOVE: begin
            if (seen_ff || match) begin
               valid_in  = right_flags.valid;
               handle_in = right_handle;
               prio_in   = right_prio;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         seen_ff  <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         seen_ff  <= seen_in;
      end
   end

   always_ff @(posedge clock) begin
      handle_ff <= handle_in;
      prio_ff   <= prio_in;
   end

endmodule

`default_nettype wire

FILE: rtl/sorted_priority_work_queue_top.sv
// Sorted priority work queue: up to QUEUE_DEPTH handles kept in a chain of cells ordered by
// falling priority, equal priorities newest first. A transaction is taken when start is high
// and busy is low; its single result appears on the rsp_ ports for one cycle with rsp_valid
// high and cannot be held off. Insert, pop and conditional pop keep busy low and the result
// is strobed in the cycle after acceptance, so one of them may be issued every cycle.
// Remove by handle holds busy through the FSM_WAVE and FSM_REMOVE states and registers its
// result from FSM_REMOVE: the front-most-match flag ripples down the chain one cell per
// cycle in FSM_WAVE, then FSM_REMOVE closes the gap. rsp_occupancy holds the number of
// queued items after the transaction.
`default_nettype none

module sorted_priority_work_queue_top #(
   parameter int QUEUE_DEPTH = 16,
   parameter int HANDLE_BITS = 8
) (
   input  wire                                clock,
   input  wire                                reset,
   input  wire                                start,
   output logic                               busy,
   input  wire  [1:0]                         req_func,
   input  wire  [HANDLE_BITS-1:0]             req_item_handle,
   input  wire  [swq_pkg::PRIO_BITS-1:0]      req_item_priority,
   input  wire  [swq_pkg::PRIO_BITS-1:0]      req_threshold,
   output logic                               rsp_valid,
   output logic [2:0]                         rsp_status,
   output logic [HANDLE_BITS-1:0]             rsp_out_handle,
   output logic [swq_pkg::PRIO_BITS-1:0]      rsp_out_priority,
   output logic [$clog2(QUEUE_DEPTH+1)-1:0]   rsp_occupancy
);

   localparam int CNT_BITS  = $clog2(QUEUE_DEPTH + 1);
   localparam int WAVE_BITS = $clog2(QUEUE_DEPTH);

   swq_pkg::fsm_type              state_ff, state_in;
   swq_pkg::cmd_type              cmd;
   logic [CNT_BITS-1:0]           count_ff, count_in;
   logic [WAVE_BITS-1:0]          wave_ff, wave_in;
   logic [HANDLE_BITS-1:0]        rem_handle_ff, rem_handle_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   swq_pkg::status_type           status_ff, status_in;
   logic [HANDLE_BITS-1:0]        out_handle_ff, out_handle_in;
   logic [swq_pkg::PRIO_BITS-1:0] out_prio_ff, out_prio_in;
   logic                          accept;
   logic                          full;
   logic                          empty;
   swq_pkg::func_type             func;

   swq_pkg::cell_flags_type       cell_flags [QUEUE_DEPTH];
   logic [HANDLE_BITS-1:0]        cell_handle [QUEUE_DEPTH];
   logic [swq_pkg::PRIO_BITS-1:0] cell_prio [QUEUE_DEPTH];
   swq_pkg::cell_flags_type       left_flags [QUEUE_DEPTH];
   logic [HANDLE_BITS-1:0]        left_handle [QUEUE_DEPTH];
   logic [swq_pkg::PRIO_BITS-1:0] left_prio [QUEUE_DEPTH];
   swq_pkg::cell_flags_type       right_flags [QUEUE_DEPTH];
   logic [HANDLE_BITS-1:0]        right_handle [QUEUE_DEPTH];
   logic [swq_pkg::PRIO_BITS-1:0] right_prio [QUEUE_DEPTH];

   genvar k;
   generate
      for (k = 0; k < QUEUE_DEPTH; k++) begin : g_cell
         if (k == 0) begin : g_head
            assign left_flags[k]  = '0;
            assign left_handle[k] = '0;
            assign left_prio[k]   = '0;
         end else begin : g_mid_l
            assign left_flags[k]  = cell_flags[k-1];
            assign left_handle[k] = cell_handle[k-1];
            assign left_prio[k]   = cell_prio[k-1];
         end
         if (k == QUEUE_DEPTH - 1) begin : g_tail
            assign right_flags[k]  = '0;
            assign right_handle[k] = '0;
            assign right_prio[k]   = '0;
         end else begin : g_mid_r
            assign right_flags[k]  = cell_flags[k+1];
            assign right_handle[k] = cell_handle[k+1];
            assign right_prio[k]   = cell_prio[k+1];
         end
         swq_cell #(
            .HANDLE_BITS(HANDLE_BITS)
         ) u_cell (
            .clock        (clock),
            .reset        (reset),
            .cmd          (cmd),
            .ins_handle   (req_item_handle),
            .ins_prio     (req_item_priority),
            .rem_handle   (rem_handle_ff),
            .left_flags   (left_flags[k]),
            .left_handle  (left_handle[k]),
            .left_prio    (left_prio[k]),
            .right_flags  (right_flags[k]),
            .right_handle (right_handle[k]),
            .right_prio   (right_prio[k]),
            .flags        (cell_flags[k]),
            .handle       (cell_handle[k]),
            .prio         (cell_prio[k])
         );
      end
   endgenerate

   assign func   = swq_pkg::func_type'(req_func);
   assign busy   = (state_ff != swq_pkg::FSM_IDLE);
   assign accept = start && !busy;
   assign full   = (count_ff == CNT_BITS'(QUEUE_DEPTH));
   assign empty  = (count_ff == '0);

   always_comb begin
      state_in      = state_ff;
      cmd           = swq_pkg::CMD_HOLD;
      count_in      = count_ff;
      wave_in       = wave_ff;
      rem_handle_in = rem_handle_ff;
      rsp_valid_in  = 1'b0;
      status_in     = status_ff;
      out_handle_in = out_handle_ff;
      out_prio_in   = out_prio_ff;
      unique case (state_ff)
         swq_pkg::FSM_IDLE: begin
            if (accept) begin
               rsp_valid_in  = 1'b1;
               status_in     = swq_pkg::STAT_OK;
               out_handle_in = '0;
               out_prio_in   = '0;
               unique case (func)
                  swq_pkg::FUNC_INSERT: begin
                     if (full) begin
                        status_in = swq_pkg::STAT_FULL;
                     end else begin
                        cmd      = swq_pkg::CMD_INSERT;
                        count_in = count_ff + 1'b1;
                     end
                  end
                  swq_pkg::FUNC_REMOVE: begin
                     // result comes once the match flag has swept the chain
                     rsp_valid_in  = 1'b0;
                     rem_handle_in = req_item_handle;
                     wave_in       = '0;
                     state_in      = swq_pkg::FSM_WAVE;
                  end
                  swq_pkg::FUNC_POP,
                  swq_pkg::FUNC_POP_IF: begin
                     priority if (empty) begin
                        status_in = swq_pkg::STAT_EMPTY;
                     end else if (func == swq_pkg::FUNC_POP_IF &&
                                  cell_prio[0] < req_threshold) begin
                        status_in = swq_pkg::STAT_BELOW;
                     end else begin
                        cmd           = swq_pkg::CMD_POP;
                        count_in      = count_ff - 1'b1;
                        out_handle_in = cell_handle[0];
                        out_prio_in   = cell_prio[0];
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         swq_pkg::FSM_WAVE: begin
            cmd     = swq_pkg::CMD_WAVE;
            wave_in = wave_ff + 1'b1;
            if (wave_ff == WAVE_BITS'(QUEUE_DEPTH - 2)) begin
               state_in = swq_pkg::FSM_REMOVE;
            end
         end
         swq_pkg::FSM_REMOVE: begin
            cmd          = swq_pkg::CMD_REMOVE;
            rsp_valid_in = 1'b1;
            state_in     = swq_pkg::FSM_IDLE;
            if (cell_flags[QUEUE_DEPTH-1].seen) begin
               status_in = swq_pkg::STAT_OK;
               count_in  = count_ff - 1'b1;
            end else begin
               status_in = swq_pkg::STAT_NOT_FOUND;
            end
         end
         default: begin
            state_in = swq_pkg::FSM_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= swq_pkg::FSM_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      wave_ff       <= wave_in;
      rem_handle_ff <= rem_handle_in;
      status_ff     <= status_in;
      out_handle_ff <= out_handle_in;
      out_prio_ff   <= out_prio_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = status_ff;
   assign rsp_out_handle   = out_handle_ff;
   assign rsp_out_priority = out_prio_ff;
   assign rsp_occupancy    = count_ff;

`ifndef SYNTHESIS
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_BITS'(QUEUE_DEPTH))
      else $error("occupancy beyond queue depth");

   a_head_valid: assert property (@(posedge clock) disable iff (reset)
      cell_flags[0].valid == (count_ff != '0))
      else $error("head cell validity disagrees with occupancy");

   a_tail_valid: assert property (@(posedge clock) disable iff (reset)
      cell_flags[QUEUE_DEPTH-1].valid == full)
      else $error("tail cell validity disagrees with occupancy");

   a_remove_resp: assert property (@(posedge clock) disable iff (reset)
      state_ff == swq_pkg::FSM_REMOVE |=> rsp_valid && !busy)
      else $error("remove finished without a result");
`endif

endmodule

`default_nettype wire
